// ===== src/lpg_pkg.sv =====
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared widths and the line command type of the line pixel generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

    // register and field widths
    localparam int CFG_W   = 7;
    localparam int DIM_W   = 7;
    localparam int IN_W    = 16;
    localparam int COORD_W = 6;
    localparam int IDX_W   = 12;
    localparam int COLOR_W = 32;
    localparam int ERR_W   = COORD_W + 2;

    // packed word widths
    localparam int S_DATA_W = 4 * IN_W + COLOR_W;
    localparam int M_DATA_W = 2 * COORD_W + IDX_W + COLOR_W;

    // configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // one line, ready to walk: start, stop, spans, directions, first error, frame width, color
    typedef struct packed {
        logic [COORD_W-1:0]      x0;
        logic [COORD_W-1:0]      y0;
        logic [COORD_W-1:0]      x1;
        logic [COORD_W-1:0]      y1;
        logic [COORD_W-1:0]      dx;
        logic [COORD_W-1:0]      dy;
        logic                    sx_neg;
        logic                    sy_neg;
        logic signed [ERR_W-1:0] err;
        logic [DIM_W-1:0]        width;
        logic [COLOR_W-1:0]      color;
    } lpg_cmd_t;

    // queue status seen by front and back
    typedef struct packed {
        logic empty;
        logic full;
    } lpg_q_stat_t;

    // walker status
    typedef struct packed {
        logic busy;
        logic emit;
        logic emit_last;
    } lpg_back_stat_t;

endpackage

// ===== src/lpg_front.sv =====
// ----------------------------------------------------------------------------
// lpg_front
// Clips a line request to the frame, drops it if both ends are off one axis,
// or turns it into a walk command (axis-aligned lines are reordered to rise).
// ----------------------------------------------------------------------------
module lpg_front
    import lpg_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  logic [CFG_W-1:0]    image_width,
    input  logic [CFG_W-1:0]    image_height,
    input  logic [S_DATA_W-1:0] req_data,
    output logic                req_keep,
    output lpg_cmd_t            req_cmd
);

    localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

    logic [DIM_W-1:0]   w_sat;
    logic [DIM_W-1:0]   h_sat;
    logic [IN_W-1:0]    ax, ay, bx, by;
    logic [IN_W-1:0]    w_ext, h_ext;
    logic               ax_out, ay_out, bx_out, by_out;
    logic [COORD_W-1:0] w_last, h_last;
    logic [COORD_W-1:0] cax, cay, cbx, cby;
    logic [COORD_W-1:0] sx0, sy0, sx1, sy1;
    logic [COORD_W-1:0] dx, dy;
    logic               x_up, y_up;

    // frame size saturated to the largest frame
    assign w_sat = (image_width > MAX_DIM_V) ? MAX_DIM_V : image_width;
    assign h_sat = (image_height > MAX_DIM_V) ? MAX_DIM_V : image_height;

    // unpack request word
    assign ax = req_data[IN_W-1:0];
    assign ay = req_data[2*IN_W-1:IN_W];
    assign bx = req_data[3*IN_W-1:2*IN_W];
    assign by = req_data[4*IN_W-1:3*IN_W];

    assign w_ext = IN_W'(w_sat);
    assign h_ext = IN_W'(h_sat);

    assign ax_out = ax >= w_ext;
    assign bx_out = bx >= w_ext;
    assign ay_out = ay >= h_ext;
    assign by_out = by >= h_ext;

    // empty frame or both ends off one axis
    assign req_keep = (w_sat != '0) && (h_sat != '0) && !(ax_out && bx_out)
                      && !(ay_out && by_out);

    // clamp to last column / row
    assign w_last = COORD_W'(w_sat - DIM_W'(1));
    assign h_last = COORD_W'(h_sat - DIM_W'(1));
    assign cax = ax_out ? w_last : ax[COORD_W-1:0];
    assign cbx = bx_out ? w_last : bx[COORD_W-1:0];
    assign cay = ay_out ? h_last : ay[COORD_W-1:0];
    assign cby = by_out ? h_last : by[COORD_W-1:0];

    // horizontal lines rise in x, vertical lines rise in y
    always_comb begin
        sx0 = cax;
        sy0 = cay;
        sx1 = cbx;
        sy1 = cby;
        if (cay == cby) begin
            if (cbx < cax) begin
                sx0 = cbx;
                sx1 = cax;
            end
        end else if (cax == cbx) begin
            if (cby < cay) begin
                sy0 = cby;
                sy1 = cay;
            end
        end
    end

    // spans and directions
    assign x_up = sx1 > sx0;
    assign y_up = sy1 > sy0;
    assign dx   = x_up ? (sx1 - sx0) : (sx0 - sx1);
    assign dy   = y_up ? (sy1 - sy0) : (sy0 - sy1);

    always_comb begin
        req_cmd.x0     = sx0;
        req_cmd.y0     = sy0;
        req_cmd.x1     = sx1;
        req_cmd.y1     = sy1;
        req_cmd.dx     = dx;
        req_cmd.dy     = dy;
        req_cmd.sx_neg = !x_up;
        req_cmd.sy_neg = !y_up;
        // first error, halved toward zero
        if (dx > dy) begin
            req_cmd.err = ERR_W'(dx >> 1);
        end else begin
            req_cmd.err = -(ERR_W'(dy >> 1));
        end
        req_cmd.width  = w_sat;
        req_cmd.color  = req_data[S_DATA_W-1:4*IN_W];
    end

endmodule

// ===== src/lpg_queue.sv =====
// ----------------------------------------------------------------------------
// lpg_queue
// Small register queue of walk commands between front and back.
// ----------------------------------------------------------------------------
module lpg_queue
    import lpg_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  lpg_cmd_t    push_cmd,
    input  logic        pop,
    output lpg_cmd_t    pop_cmd,
    output lpg_q_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lpg_cmd_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    // pointer wrap and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/lpg_back.sv =====
// ----------------------------------------------------------------------------
// lpg_back
// Walks one command a pixel a cycle with Bresenham stepping while the output
// is not stalled, and drives the registered pixel word stream.
// ----------------------------------------------------------------------------
module lpg_back
    import lpg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    input  lpg_cmd_t            q_cmd,
    output logic                q_pop,
    output lpg_back_stat_t      stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    localparam int PROD_W = COORD_W + DIM_W;

    state_t                  state_reg;
    logic [COORD_W-1:0]      cur_x_reg, cur_y_reg;
    logic [COORD_W-1:0]      stop_x_reg, stop_y_reg;
    logic [COORD_W-1:0]      dx_reg, dy_reg;
    logic                    sx_neg_reg, sy_neg_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic [DIM_W-1:0]        width_reg;
    logic [COLOR_W-1:0]      color_reg;
    logic                    m_valid_reg;
    logic [M_DATA_W-1:0]     m_data_reg;
    logic                    m_last_reg;

    logic                    out_adv;
    logic                    emit;
    logic                    at_end;
    logic signed [ERR_W-1:0] dx_s, dy_s;
    logic                    step_x, step_y;
    logic signed [ERR_W-1:0] err_next;
    logic [COORD_W-1:0]      x_next, y_next;
    logic [PROD_W-1:0]       row_base;
    logic [PROD_W-1:0]       lin_sum;

    // output slot frees when empty or taken
    assign out_adv = !m_valid_reg || m_tready;
    assign emit    = (state_reg == ST_WALK) && out_adv;
    assign at_end  = (cur_x_reg == stop_x_reg) && (cur_y_reg == stop_y_reg);
    assign q_pop   = (state_reg == ST_IDLE) && !q_empty;

    assign stat.busy      = (state_reg == ST_WALK);
    assign stat.emit      = emit;
    assign stat.emit_last = emit && at_end;

    // bresenham step
    assign dx_s   = ERR_W'(dx_reg);
    assign dy_s   = ERR_W'(dy_reg);
    assign step_x = err_reg > -dx_s;
    assign step_y = err_reg < dy_s;

    always_comb begin
        err_next = err_reg;
        x_next   = cur_x_reg;
        y_next   = cur_y_reg;
        if (step_x) begin
            x_next = sx_neg_reg ? cur_x_reg - COORD_W'(1) : cur_x_reg + COORD_W'(1);
        end
        if (step_y) begin
            y_next = sy_neg_reg ? cur_y_reg - COORD_W'(1) : cur_y_reg + COORD_W'(1);
        end
        if (step_x && step_y) begin
            err_next = err_reg - dy_s + dx_s;
        end else if (step_x) begin
            err_next = err_reg - dy_s;
        end else if (step_y) begin
            err_next = err_reg + dx_s;
        end
    end

    // linear index: row times width plus column
    assign row_base = PROD_W'(cur_y_reg) * PROD_W'(width_reg);
    assign lin_sum  = row_base + PROD_W'(cur_x_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (emit && at_end) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (out_adv) begin
                m_valid_reg <= emit;
            end
        end
    end

    // walk registers and pixel word
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_x_reg  <= q_cmd.x0;
            cur_y_reg  <= q_cmd.y0;
            stop_x_reg <= q_cmd.x1;
            stop_y_reg <= q_cmd.y1;
            dx_reg     <= q_cmd.dx;
            dy_reg     <= q_cmd.dy;
            sx_neg_reg <= q_cmd.sx_neg;
            sy_neg_reg <= q_cmd.sy_neg;
            err_reg    <= q_cmd.err;
            width_reg  <= q_cmd.width;
            color_reg  <= q_cmd.color;
        end else if (emit) begin
            cur_x_reg <= x_next;
            cur_y_reg <= y_next;
            err_reg   <= err_next;
        end
        if (emit) begin
            m_data_reg <= {color_reg, IDX_W'(lin_sum), cur_y_reg, cur_x_reg};
            m_last_reg <= at_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== src/line_pixel_generator_core.sv =====
// ----------------------------------------------------------------------------
// line_pixel_generator_core
// Line rasterizer: clips a line request to the frame and streams the pixel
// writes of the line, one word per pixel.
// ----------------------------------------------------------------------------
//  channel  | direction | word contents (low bit first)
//  s_       | in        | start_x, start_y, end_x, end_y, line_color
//  m_       | out       | pixel_x, pixel_y, pixel_index, pixel_color; tlast
//  cfg_     | in        | register 0 image_width, register 1 image_height
//
// the walker loads a line from the command queue in its idle state, then walks
// it one pixel per cycle while m_ is not stalled (at most MAX_DIM pixels)
// the front clips and classifies in the accept cycle; requests that it drops
// are not queued and produce no word
// reset clears the queue, the walker and the output slot; sizes reset to 64
// a stalled m_ side freezes the walker; s_ stays ready while the queue has room
// ----------------------------------------------------------------------------
module line_pixel_generator_core
    import lpg_pkg::*;
#(
    parameter int MAX_DIM   = 64,
    parameter int Q_DEPTH   = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    // start_x, start_y, end_x, end_y, line_color
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // pixel_x, pixel_y, pixel_index, pixel_color
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic                m_tlast,
    input  logic                cfg_wr_en,
    input  logic                cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(64);

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             req_keep;
    lpg_cmd_t         req_cmd;
    lpg_cmd_t         q_cmd;
    logic             q_push;
    logic             q_pop;
    lpg_q_stat_t      q_stat;
    lpg_back_stat_t   back_stat;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // front: clip and classify
    lpg_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .image_width  (width_reg),
        .image_height (height_reg),
        .req_data     (s_tdata),
        .req_keep     (req_keep),
        .req_cmd      (req_cmd)
    );

    assign s_tready = !q_stat.full;
    assign q_push   = s_tvalid && s_tready && req_keep;

    // command queue
    lpg_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (req_cmd),
        .pop      (q_pop),
        .pop_cmd  (q_cmd),
        .stat     (q_stat)
    );

    // back: pixel walker
    lpg_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_stat.empty),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .stat     (back_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // queue never reports full and empty together
    a_q_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    // nothing pending means no new word appears
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        (!back_stat.busy && q_stat.empty && !m_tvalid) |=> !m_tvalid)
        else $error("pixel word without a line");

    // walker goes idle after the end pixel
    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        back_stat.emit_last |=> !back_stat.busy)
        else $error("walker still busy after end pixel");

    // an emitted end pixel carries tlast
    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        back_stat.emit |=> (m_tvalid && (m_tlast == $past(back_stat.emit_last))))
        else $error("tlast does not match end pixel");

endmodule

// ===== verif/line_pixel_generator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_pixel_generator_core_tb
// Self-checking bench for the line rasterizer. Line requests go in on the s_
// stream and pixel words come back on the m_ stream. A scoreboard walks each
// accepted line itself and compares every pixel word field by field in order.
// Frame sizes are changed between phases while the block is idle. Both stream
// sides idle at random, and the sink also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module line_pixel_generator_core_tb;
    import lpg_pkg::*;

    localparam int   MAX_DIM          = 64;
    localparam int   CLK_PERIOD       = 20;
    localparam int   DRAIN_CYCLES     = 2 * (MAX_DIM + 2);
    localparam int   LONG_HOLD        = 400;
    localparam int   TIMEOUT_CYCLES   = 800_000;
    localparam int   MAX_REPORTS      = 10;
    localparam int   RANDOM_PHASES    = 8;
    localparam int   LINES_PER_PHASE  = 51;

    // one pixel write as seen on the m_ side
    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [IDX_W-1:0]   pidx;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_t;

    // walks accepted lines and holds the pixel words still to come
    class line_scoreboard;
        logic [CFG_W-1:0]   frame_width;
        logic [CFG_W-1:0]   frame_height;
        logic [COLOR_W-1:0] held_color;
        pixel_t             pending_pixels[$];
        int unsigned        failures;

        function new();
            frame_width  = 64;
            frame_height = 64;
            held_color   = '0;
            failures     = 0;
        endfunction

        function int sat_dim(logic [CFG_W-1:0] v);
            return (v > MAX_DIM) ? MAX_DIM : int'(v);
        endfunction

        function void write_reg(logic idx, logic [CFG_W-1:0] val);
            if (idx == REG_IMAGE_WIDTH) begin
                frame_width = val;
            end else begin
                frame_height = val;
            end
        endfunction

        function void log_failure(string msg);
            failures++;
            if (failures <= MAX_REPORTS) begin
                $display("[%0t] %s", $realtime, msg);
            end
        endfunction

        function void push_pixel(int x, int y, int w, bit last);
            pixel_t p;
            int     idx;
            idx     = y * w + x;
            p.px    = x[COORD_W-1:0];
            p.py    = y[COORD_W-1:0];
            p.pidx  = idx[IDX_W-1:0];
            p.color = held_color;
            p.last  = last;
            pending_pixels.push_back(p);
        endfunction

        // clip, classify and walk one accepted line request
        function void note_line(logic [S_DATA_W-1:0] word);
            int w, h, ax, ay, bx, by;
            int x, y, lo, hi, dx, dy, sx, sy, e, e2, n;
            bit done;
            w  = sat_dim(frame_width);
            h  = sat_dim(frame_height);
            ax = word[IN_W-1:0];
            ay = word[2*IN_W-1:IN_W];
            bx = word[3*IN_W-1:2*IN_W];
            by = word[4*IN_W-1:3*IN_W];
            // empty frame or line fully off one axis
            if (w == 0 || h == 0 || (ax >= w && bx >= w) || (ay >= h && by >= h)) begin
                return;
            end
            held_color = word[S_DATA_W-1:4*IN_W];
            if (ax >= w) ax = w - 1;
            if (bx >= w) bx = w - 1;
            if (ay >= h) ay = h - 1;
            if (by >= h) by = h - 1;
            n = 0;
            if (ay == by) begin
                // horizontal, also a single point: rising x
                lo = (ax < bx) ? ax : bx;
                hi = (ax < bx) ? bx : ax;
                for (x = lo; n < MAX_DIM; x++) begin
                    done = (x == hi);
                    push_pixel(x, ay, w, done);
                    n++;
                    if (done) break;
                end
            end else if (ax == bx) begin
                // vertical: rising y
                lo = (ay < by) ? ay : by;
                hi = (ay < by) ? by : ay;
                for (y = lo; n < MAX_DIM; y++) begin
                    done = (y == hi);
                    push_pixel(ax, y, w, done);
                    n++;
                    if (done) break;
                end
            end else begin
                // general slope, start to end
                x  = ax;
                y  = ay;
                dx = (bx > ax) ? bx - ax : ax - bx;
                dy = (by > ay) ? by - ay : ay - by;
                sx = (bx > ax) ? 1 : -1;
                sy = (by > ay) ? 1 : -1;
                e  = ((dx > dy) ? dx : -dy) / 2;
                forever begin
                    done = (x == bx && y == by);
                    push_pixel(x, y, w, done);
                    n++;
                    if (done || n >= MAX_DIM) break;
                    e2 = e;
                    if (e2 > -dx) begin
                        e -= dy;
                        x += sx;
                    end
                    if (e2 < dy) begin
                        e += dx;
                        y += sy;
                    end
                end
            end
        endfunction

        function void compare(string name, logic [COLOR_W-1:0] want, logic [COLOR_W-1:0] got);
            if (got !== want) begin
                log_failure($sformatf("mismatch %s: expected %0h, got %0h", name, want, got));
            end
        endfunction

        // compare one accepted pixel word with the oldest one pending
        function void check_pixel(logic [M_DATA_W-1:0] word, logic tlast);
            pixel_t want;
            pixel_t got;
            got.px    = word[COORD_W-1:0];
            got.py    = word[2*COORD_W-1:COORD_W];
            got.pidx  = word[2*COORD_W+IDX_W-1:2*COORD_W];
            got.color = word[M_DATA_W-1:2*COORD_W+IDX_W];
            got.last  = tlast;
            if (pending_pixels.size() == 0) begin
                log_failure($sformatf("unexpected word x=%0d y=%0d", got.px, got.py));
                return;
            end
            want = pending_pixels.pop_front();
            compare("pixel_x", want.px, got.px);
            compare("pixel_y", want.py, got.py);
            compare("pixel_index", want.pidx, got.pidx);
            compare("pixel_color", want.color, got.color);
            compare("last_pixel", want.last, got.last);
        endfunction

        function void flush_leftovers();
            pixel_t p;
            while (pending_pixels.size() != 0) begin
                p = pending_pixels.pop_front();
                log_failure($sformatf("missing word x=%0d y=%0d", p.px, p.py));
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic                m_tlast;
    logic                cfg_wr_en;
    logic                cfg_addr;
    logic [CFG_W-1:0]    cfg_wdata;

    line_scoreboard sb = new();
    int             hold_count = 0;
    int             src_quiet  = 0;
    int             sink_quiet = 0;

    line_pixel_generator_core #(
        .MAX_DIM (MAX_DIM)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always begin
        #(CLK_PERIOD / 2) aclk = 1'b1;
        #(CLK_PERIOD / 2) aclk = 1'b0;
    end

    // idle cycles before the next word, with occasional stretches of none
    function automatic int draw_wait(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 3);
    endfunction

    // edge, just over, or anywhere in the 16-bit range
    function automatic logic [IN_W-1:0] wild_coord(int lim);
        case ($urandom_range(0, 2))
            0:       return IN_W'($urandom_range(0, 65535));
            1:       return IN_W'(lim - 1 + int'($urandom_range(0, 3)));
            default: return IN_W'($urandom_range(0, lim - 1));
        endcase
    endfunction

    // handshake monitor: note accepted lines, check accepted pixels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_line(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                sb.check_pixel(m_tdata, m_tlast);
            end
        end
    end

    // pixel sink with random stalls and one long hold-off on request
    initial begin : pixel_sink
        int stall;
        int holds_done;
        holds_done = 0;
        forever begin
            if (hold_count > holds_done) begin
                stall = LONG_HOLD;
                holds_done++;
            end else begin
                stall = draw_wait(sink_quiet);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_line(input logic [IN_W-1:0] ax, input logic [IN_W-1:0] ay,
                             input logic [IN_W-1:0] bx, input logic [IN_W-1:0] by,
                             input logic [COLOR_W-1:0] color);
        int gap;
        gap = draw_wait(src_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {color, by, bx, ay, ax};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // mostly in-frame lines, some flat, vertical, points and wild ends
    task automatic send_random_line();
        int              lim_w;
        int              lim_h;
        logic [IN_W-1:0] ax, ay, bx, by;
        lim_w = sb.sat_dim(sb.frame_width);
        lim_h = sb.sat_dim(sb.frame_height);
        if (lim_w == 0) lim_w = 1;
        if (lim_h == 0) lim_h = 1;
        ax = IN_W'($urandom_range(0, lim_w - 1));
        ay = IN_W'($urandom_range(0, lim_h - 1));
        bx = IN_W'($urandom_range(0, lim_w - 1));
        by = IN_W'($urandom_range(0, lim_h - 1));
        case ($urandom_range(0, 9))
            6: by = ay;
            7: bx = ax;
            8: begin
                bx = ax;
                by = ay;
            end
            9: begin
                ax = wild_coord(lim_w);
                ay = wild_coord(lim_h);
                bx = wild_coord(lim_w);
                by = wild_coord(lim_h);
            end
            default: ;
        endcase
        send_line(ax, ay, bx, by, $urandom());
    endtask

    // stop offering, wait for every pending pixel, then let the walker drain
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        settle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // stimulus and verdict
    initial begin : stimulus
        logic [CFG_W-1:0] phase_w;
        logic [CFG_W-1:0] phase_h;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= REG_IMAGE_WIDTH;
        cfg_wdata <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset sizes: point, flat, vertical, full spans, all slopes
        send_line(16'd5, 16'd5, 16'd5, 16'd5, 32'h0000_0000);
        send_line(16'd40, 16'd10, 16'd3, 16'd10, 32'hFFFF_FFFF);
        send_line(16'd7, 16'd50, 16'd7, 16'd2, 32'hA5A5_5A5A);
        send_line(16'd0, 16'd63, 16'd63, 16'd63, 32'h5A5A_A5A5);
        send_line(16'd0, 16'd0, 16'd0, 16'd63, 32'h0123_4567);
        send_line(16'd0, 16'd0, 16'd63, 16'd63, 32'h89AB_CDEF);
        send_line(16'd63, 16'd0, 16'd0, 16'd63, 32'hFEDC_BA98);
        send_line(16'd2, 16'd3, 16'd50, 16'd20, 32'h7654_3210);
        send_line(16'd30, 16'd60, 16'd20, 16'd1, 32'h8000_0001);
        send_line(16'd60, 16'd5, 16'd1, 16'd9, 32'h7FFF_FFFE);
        // line off frame: both ends off one axis
        send_line(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_line(16'd64, 16'd0, 16'hFFFF, 16'd10, 32'h1111_1111);
        send_line(16'd0, 16'd100, 16'd20, 16'hFFFF, 32'h2222_2222);
        // one or both ends clamped
        send_line(16'd0, 16'd0, 16'hFFFF, 16'd30, 32'h3333_3333);
        send_line(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 32'h4444_4444);

        // empty frame, either register zero
        set_frame(0, 64);
        send_line(16'd0, 16'd0, 16'd10, 16'd10, 32'h5555_5555);
        send_line(16'd3, 16'd3, 16'd3, 16'd3, 32'h6666_6666);
        set_frame(64, 0);
        send_line(16'd0, 16'd0, 16'd10, 16'd0, 32'h7777_7777);

        // single-pixel frame
        set_frame(1, 1);
        send_line(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 32'h9999_9999);
        send_line(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 32'hAAAA_AAAA);

        // oversized registers saturate to the largest frame
        set_frame(127, 127);
        send_line(16'd0, 16'd0, 16'd100, 16'd100, 32'hBBBB_BBBB);
        send_line(16'd70, 16'd70, 16'd70, 16'd90, 32'hCCCC_CCCC);

        // random phases over several frame sizes
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin phase_w = 64;  phase_h = 64;  end
                1: begin phase_w = 127; phase_h = 127; end
                2: begin phase_w = 5;   phase_h = 3;   end
                3: begin phase_w = 1;   phase_h = 40;  end
                4: begin phase_w = 64;  phase_h = 2;   end
                5: begin phase_w = 100; phase_h = 17;  end
                default: begin
                    phase_w = CFG_W'($urandom_range(1, 80));
                    phase_h = CFG_W'($urandom_range(1, 80));
                end
            endcase
            set_frame(phase_w, phase_h);
            for (int i = 0; i < LINES_PER_PHASE; i++) begin
                // long sink hold-off so the block backs up into s_tready
                if (phase == 0 && i == 10) hold_count++;
                // sender pause until all pending pixels are out
                if (phase == 2 && i == 27) settle();
                send_random_line();
            end
        end

        settle();
        sb.flush_leftovers();
        if (sb.failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("FAIL");
        $finish;
    end

endmodule
